// ----- hw/rtl/piecewise_linear_curve_table_unit_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the piecewise-linear curve table unit
// Concurrent checks, clocked and reset-qualified.
// ----------------------------------------------------------------------------
`ifndef PIECEWISE_LINEAR_CURVE_TABLE_UNIT_ASSERT_SVH
`define PIECEWISE_LINEAR_CURVE_TABLE_UNIT_ASSERT_SVH

// condition holds at every edge out of reset
`define PLCT_ASSERT_ALWAYS(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// antecedent implies consequent in the same cycle
`define PLCT_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// antecedent implies consequent in the next cycle
`define PLCT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- hw/rtl/plct_pkg.sv -----
// ----------------------------------------------------------------------------
// plct_pkg
// Types, constants and helpers shared by the curve table controller and datapath.
// ----------------------------------------------------------------------------
package plct_pkg;

    localparam int FRAC_BITS  = 12;
    localparam int VAL_W      = FRAC_BITS + 1;
    localparam int MAX_POINTS = 32;
    localparam int IDX_W      = $clog2(MAX_POINTS);
    localparam int CNT_W      = $clog2(MAX_POINTS + 1);
    localparam int PROD_W     = 2 * VAL_W;
    localparam int DCNT_W     = $clog2(PROD_W + 1);

    localparam logic [VAL_W-1:0] ONE_VAL        = VAL_W'(1 << FRAC_BITS);
    localparam logic [VAL_W-1:0] MERGE_DIST_RST = VAL_W'(205);
    localparam logic [CNT_W-1:0] MAX_CNT        = CNT_W'(MAX_POINTS);
    localparam logic [DCNT_W-1:0] DIV_STEPS     = DCNT_W'(PROD_W);

    localparam int CFG_ADDR_W = 3;
    localparam logic REG_MERGE_DIST = 1'b0;

    typedef enum logic [2:0] {
        CMD_CLEAR     = 3'd0,
        CMD_INS_VAL   = 3'd1,
        CMD_INS_INTERP = 3'd2,
        CMD_DELETE    = 3'd3,
        CMD_OVERWRITE = 3'd4,
        CMD_EVALUATE  = 3'd5,
        CMD_SET_ACTIVE = 3'd6,
        CMD_NOP       = 3'd7
    } t_cmd;

    typedef enum logic [4:0] {
        UOP_NONE,
        UOP_LATCH,
        UOP_CLEAR,
        UOP_SCAN_INIT,
        UOP_EMPTY,
        UOP_PREV,
        UOP_SCAN_HIT,
        UOP_SCAN_END,
        UOP_SCAN_NEXT,
        UOP_EVAL_MISS,
        UOP_EVAL_FLAT,
        UOP_DIV_INIT,
        UOP_DIV_STEP,
        UOP_EVAL_FIN,
        UOP_INS_FULL,
        UOP_INS_FOUND,
        UOP_SH_INIT,
        UOP_SH_PLACE,
        UOP_SH_DEC,
        UOP_SH_WRITE,
        UOP_DEL_INIT,
        UOP_DEL_LAST,
        UOP_DEL_INC,
        UOP_DEL_WRITE,
        UOP_OVERWRITE,
        UOP_SET_ACTIVE,
        UOP_RESPOND
    } t_uop;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_SC_W0,
        ST_SC_PREV,
        ST_SC_W,
        ST_SC_CHK,
        ST_AFTER,
        ST_EVAL,
        ST_DIV,
        ST_FIN,
        ST_INS,
        ST_SH_CHK,
        ST_SH_RD,
        ST_SH_WR,
        ST_DL_CHK,
        ST_DL_RD,
        ST_DL_WR,
        ST_RESP
    } t_state;

    typedef struct packed {
        t_cmd cmd;
        logic count_zero;
        logic idx_ok;
        logic ptr_end;
        logic scan_ge;
        logic hit;
        logic seg_flat;
        logic div_busy;
        logic add;
        logic table_full;
        logic sh_done;
        logic dl_last;
        logic out_free;
    } t_dp_stat;

    function automatic logic [VAL_W-1:0] clamp_one(input logic [VAL_W-1:0] v);
        return (v > ONE_VAL) ? ONE_VAL : v;
    endfunction

endpackage

// ----- hw/rtl/plct_ctrl.sv -----
// ----------------------------------------------------------------------------
// plct_ctrl
// Sequencer for the curve table: issues at most one datapath micro-op per cycle.
// ----------------------------------------------------------------------------
module plct_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  plct_pkg::t_dp_stat i_stat,
    output logic               o_ready,
    output plct_pkg::t_uop     o_uop
);

    plct_pkg::t_state r_state;
    plct_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= plct_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            plct_pkg::ST_IDLE: begin
                if (i_valid) n_state = plct_pkg::ST_DISPATCH;
            end
            plct_pkg::ST_DISPATCH: begin
                unique case (i_stat.cmd)
                    plct_pkg::CMD_INS_VAL, plct_pkg::CMD_INS_INTERP,
                    plct_pkg::CMD_EVALUATE: begin
                        n_state = i_stat.count_zero ? plct_pkg::ST_AFTER : plct_pkg::ST_SC_W0;
                    end
                    plct_pkg::CMD_DELETE: begin
                        n_state = i_stat.idx_ok ? plct_pkg::ST_DL_CHK : plct_pkg::ST_RESP;
                    end
                    default: n_state = plct_pkg::ST_RESP;
                endcase
            end
            plct_pkg::ST_SC_W0:   n_state = plct_pkg::ST_SC_PREV;
            plct_pkg::ST_SC_PREV: n_state = plct_pkg::ST_SC_W;
            plct_pkg::ST_SC_W:    n_state = plct_pkg::ST_SC_CHK;
            plct_pkg::ST_SC_CHK: begin
                n_state = (i_stat.ptr_end || i_stat.scan_ge) ? plct_pkg::ST_AFTER
                                                             : plct_pkg::ST_SC_W;
            end
            plct_pkg::ST_AFTER: begin
                n_state = (i_stat.cmd == plct_pkg::CMD_INS_VAL) ? plct_pkg::ST_INS
                                                                : plct_pkg::ST_EVAL;
            end
            plct_pkg::ST_EVAL: begin
                if (i_stat.hit && !i_stat.seg_flat) begin
                    n_state = plct_pkg::ST_DIV;
                end else begin
                    n_state = (i_stat.cmd == plct_pkg::CMD_EVALUATE) ? plct_pkg::ST_RESP
                                                                     : plct_pkg::ST_INS;
                end
            end
            plct_pkg::ST_DIV: begin
                if (!i_stat.div_busy) n_state = plct_pkg::ST_FIN;
            end
            plct_pkg::ST_FIN: begin
                n_state = (i_stat.cmd == plct_pkg::CMD_EVALUATE) ? plct_pkg::ST_RESP
                                                                 : plct_pkg::ST_INS;
            end
            plct_pkg::ST_INS: begin
                n_state = (i_stat.add && !i_stat.table_full) ? plct_pkg::ST_SH_CHK
                                                             : plct_pkg::ST_RESP;
            end
            plct_pkg::ST_SH_CHK: begin
                n_state = i_stat.sh_done ? plct_pkg::ST_RESP : plct_pkg::ST_SH_RD;
            end
            plct_pkg::ST_SH_RD: n_state = plct_pkg::ST_SH_WR;
            plct_pkg::ST_SH_WR: n_state = plct_pkg::ST_SH_CHK;
            plct_pkg::ST_DL_CHK: begin
                n_state = i_stat.dl_last ? plct_pkg::ST_RESP : plct_pkg::ST_DL_RD;
            end
            plct_pkg::ST_DL_RD: n_state = plct_pkg::ST_DL_WR;
            plct_pkg::ST_DL_WR: n_state = plct_pkg::ST_DL_CHK;
            plct_pkg::ST_RESP: begin
                if (i_stat.out_free) n_state = plct_pkg::ST_IDLE;
            end
            default: n_state = plct_pkg::ST_IDLE;
        endcase
    end

    // micro-op per state
    always_comb begin
        o_ready = 1'b0;
        o_uop   = plct_pkg::UOP_NONE;
        unique case (r_state)
            plct_pkg::ST_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) o_uop = plct_pkg::UOP_LATCH;
            end
            plct_pkg::ST_DISPATCH: begin
                unique case (i_stat.cmd)
                    plct_pkg::CMD_CLEAR: o_uop = plct_pkg::UOP_CLEAR;
                    plct_pkg::CMD_INS_VAL, plct_pkg::CMD_INS_INTERP,
                    plct_pkg::CMD_EVALUATE: begin
                        o_uop = i_stat.count_zero ? plct_pkg::UOP_EMPTY : plct_pkg::UOP_SCAN_INIT;
                    end
                    plct_pkg::CMD_DELETE: begin
                        if (i_stat.idx_ok) o_uop = plct_pkg::UOP_DEL_INIT;
                    end
                    plct_pkg::CMD_OVERWRITE: begin
                        if (i_stat.idx_ok) o_uop = plct_pkg::UOP_OVERWRITE;
                    end
                    plct_pkg::CMD_SET_ACTIVE: begin
                        if (i_stat.idx_ok) o_uop = plct_pkg::UOP_SET_ACTIVE;
                    end
                    default: o_uop = plct_pkg::UOP_NONE;
                endcase
            end
            plct_pkg::ST_SC_PREV: o_uop = plct_pkg::UOP_PREV;
            plct_pkg::ST_SC_CHK: begin
                priority if (i_stat.ptr_end) o_uop = plct_pkg::UOP_SCAN_END;
                else if (i_stat.scan_ge)     o_uop = plct_pkg::UOP_SCAN_HIT;
                else                         o_uop = plct_pkg::UOP_SCAN_NEXT;
            end
            plct_pkg::ST_EVAL: begin
                priority if (!i_stat.hit)   o_uop = plct_pkg::UOP_EVAL_MISS;
                else if (i_stat.seg_flat)   o_uop = plct_pkg::UOP_EVAL_FLAT;
                else                        o_uop = plct_pkg::UOP_DIV_INIT;
            end
            plct_pkg::ST_DIV: begin
                if (i_stat.div_busy) o_uop = plct_pkg::UOP_DIV_STEP;
            end
            plct_pkg::ST_FIN: o_uop = plct_pkg::UOP_EVAL_FIN;
            plct_pkg::ST_INS: begin
                priority if (!i_stat.add)   o_uop = plct_pkg::UOP_INS_FOUND;
                else if (i_stat.table_full) o_uop = plct_pkg::UOP_INS_FULL;
                else                        o_uop = plct_pkg::UOP_SH_INIT;
            end
            plct_pkg::ST_SH_CHK: begin
                o_uop = i_stat.sh_done ? plct_pkg::UOP_SH_PLACE : plct_pkg::UOP_SH_DEC;
            end
            plct_pkg::ST_SH_WR: o_uop = plct_pkg::UOP_SH_WRITE;
            plct_pkg::ST_DL_CHK: begin
                o_uop = i_stat.dl_last ? plct_pkg::UOP_DEL_LAST : plct_pkg::UOP_DEL_INC;
            end
            plct_pkg::ST_DL_WR: o_uop = plct_pkg::UOP_DEL_WRITE;
            plct_pkg::ST_RESP: begin
                if (i_stat.out_free) o_uop = plct_pkg::UOP_RESPOND;
            end
            default: o_uop = plct_pkg::UOP_NONE;
        endcase
    end

endmodule

// ----- hw/rtl/plct_dp.sv -----
// ----------------------------------------------------------------------------
// plct_dp
// Point table memory, scan registers, divider and result register.
// ----------------------------------------------------------------------------
module plct_dp (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  plct_pkg::t_uop                      i_uop,
    input  logic [plct_pkg::VAL_W-1:0]          i_merge,
    input  logic [2:0]                          i_cmd,
    input  logic [plct_pkg::VAL_W-1:0]          i_pos,
    input  logic [plct_pkg::VAL_W-1:0]          i_value,
    input  logic [plct_pkg::IDX_W-1:0]          i_index,
    input  logic                                i_ready,
    output plct_pkg::t_dp_stat                  o_stat,
    output logic                                o_valid,
    output logic [plct_pkg::IDX_W-1:0]          o_result_index,
    output logic [plct_pkg::VAL_W-1:0]          o_curve_value,
    output logic                                o_miss,
    output logic                                o_full_res,
    output logic                                o_active_valid,
    output logic [plct_pkg::IDX_W-1:0]          o_active_index,
    output logic [plct_pkg::CNT_W-1:0]          o_point_count
);

    localparam int VW = plct_pkg::VAL_W;
    localparam int IW = plct_pkg::IDX_W;
    localparam int CW = plct_pkg::CNT_W;
    localparam int PW = plct_pkg::PROD_W;

    logic [VW-1:0] mem_pos [plct_pkg::MAX_POINTS];
    logic [VW-1:0] mem_val [plct_pkg::MAX_POINTS];

    plct_pkg::t_cmd     r_cmd;
    logic [VW-1:0]      r_q, r_v;
    logic [IW-1:0]      r_idx;
    logic [CW-1:0]      r_count;
    logic [IW-1:0]      r_act_sel;
    logic               r_act_ok;
    logic [CW-1:0]      r_ptr;
    logic [CW-1:0]      r_k;
    logic [VW-1:0]      r_p0, r_v0, r_p1, r_v1;
    logic               r_hit;
    logic [VW-1:0]      r_cv;
    logic               r_miss, r_full;
    logic [IW-1:0]      r_where;
    logic [VW-1:0]      r_rd_pos, r_rd_val;
    logic [PW-1:0]      r_num;
    logic [VW-1:0]      r_den, r_rem;
    logic               r_neg;
    logic [plct_pkg::DCNT_W-1:0] r_dcnt;

    logic               r_out_valid;
    logic [IW-1:0]      r_out_where;
    logic [VW-1:0]      r_out_cv;
    logic               r_out_miss, r_out_full, r_out_act_ok;
    logic [IW-1:0]      r_out_act_sel;
    logic [CW-1:0]      r_out_count;

    logic               mem_we;
    logic [IW-1:0]      mem_waddr;
    logic [VW-1:0]      mem_wpos, mem_wval;

    logic [VW-1:0]      pos_gap, dv, dq, dp;
    logic               dv_neg, dq_neg, dp_neg;
    logic [VW:0]        trial;
    logic               qbit;
    logic [VW:0]        sub_res;
    logic [PW:0]        sum_pos;
    logic [VW-1:0]      fin_cv, flat_cv;
    logic               ins_cmd;

    assign ins_cmd = (plct_pkg::t_cmd'(i_cmd) == plct_pkg::CMD_INS_VAL)
                  || (plct_pkg::t_cmd'(i_cmd) == plct_pkg::CMD_INS_INTERP);

    assign pos_gap = (r_p1 > r_q) ? (r_p1 - r_q) : (r_q - r_p1);
    assign dv_neg  = r_v1 < r_v0;
    assign dq_neg  = r_q < r_p0;
    assign dp_neg  = r_p1 < r_p0;
    assign dv      = dv_neg ? (r_v0 - r_v1) : (r_v1 - r_v0);
    assign dq      = dq_neg ? (r_p0 - r_q) : (r_q - r_p0);
    assign dp      = dp_neg ? (r_p0 - r_p1) : (r_p1 - r_p0);

    // restoring divide, one quotient bit a cycle
    assign trial   = {r_rem, r_num[PW-1]};
    assign qbit    = trial >= {1'b0, r_den};
    assign sub_res = trial - {1'b0, r_den};

    assign flat_cv = plct_pkg::clamp_one(r_v0);
    assign sum_pos = {1'b0, r_num} + (PW+1)'(r_v0);

    always_comb begin
        if (r_neg) begin
            if (r_num >= PW'(r_v0)) begin
                fin_cv = '0;
            end else begin
                fin_cv = plct_pkg::clamp_one(r_v0 - r_num[VW-1:0]);
            end
        end else begin
            fin_cv = (sum_pos > (PW+1)'(plct_pkg::ONE_VAL)) ? plct_pkg::ONE_VAL
                                                            : sum_pos[VW-1:0];
        end
    end

    always_comb begin
        o_stat.cmd        = r_cmd;
        o_stat.count_zero = r_count == '0;
        o_stat.idx_ok     = CW'(r_idx) < r_count;
        o_stat.ptr_end    = r_ptr >= r_count;
        o_stat.scan_ge    = r_rd_pos >= r_q;
        o_stat.hit        = r_hit;
        o_stat.seg_flat   = r_p1 == r_p0;
        o_stat.div_busy   = r_dcnt != '0;
        o_stat.add        = !r_hit || (pos_gap > i_merge);
        o_stat.table_full = r_count >= plct_pkg::MAX_CNT;
        o_stat.sh_done    = r_ptr == r_k;
        o_stat.dl_last    = (r_ptr + CW'(1)) >= r_count;
        o_stat.out_free   = !r_out_valid || i_ready;
    end

    // table write port
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_ptr[IW-1:0];
        mem_wpos  = r_rd_pos;
        mem_wval  = r_rd_val;
        unique case (i_uop)
            plct_pkg::UOP_SH_WRITE: begin
                mem_we    = 1'b1;
                mem_waddr = IW'(r_ptr + CW'(1));
            end
            plct_pkg::UOP_SH_PLACE: begin
                mem_we    = 1'b1;
                mem_waddr = r_k[IW-1:0];
                mem_wpos  = r_q;
                mem_wval  = r_v;
            end
            plct_pkg::UOP_DEL_WRITE: begin
                mem_we    = 1'b1;
                mem_waddr = IW'(r_ptr - CW'(1));
            end
            plct_pkg::UOP_OVERWRITE: begin
                mem_we    = 1'b1;
                mem_waddr = r_idx;
                mem_wpos  = r_q;
                mem_wval  = r_v;
            end
            default: mem_we = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem_pos[mem_waddr] <= mem_wpos;
            mem_val[mem_waddr] <= mem_wval;
        end
        r_rd_pos <= mem_pos[r_ptr[IW-1:0]];
        r_rd_val <= mem_val[r_ptr[IW-1:0]];
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_act_sel <= '0;
            r_act_ok  <= 1'b0;
            r_dcnt    <= '0;
        end else begin
            unique case (i_uop)
                plct_pkg::UOP_CLEAR: begin
                    r_count   <= '0;
                    r_act_sel <= '0;
                    r_act_ok  <= 1'b0;
                end
                plct_pkg::UOP_INS_FOUND: begin
                    r_act_sel <= r_k[IW-1:0];
                    r_act_ok  <= 1'b1;
                end
                plct_pkg::UOP_SH_PLACE: begin
                    r_act_sel <= r_k[IW-1:0];
                    r_act_ok  <= 1'b1;
                    r_count   <= r_count + CW'(1);
                end
                plct_pkg::UOP_DEL_INIT: begin
                    if (r_act_ok && (r_act_sel == r_idx)) begin
                        r_act_ok  <= 1'b0;
                        r_act_sel <= '0;
                    end
                end
                plct_pkg::UOP_DEL_LAST: r_count <= r_count - CW'(1);
                plct_pkg::UOP_SET_ACTIVE: begin
                    r_act_sel <= r_idx;
                    r_act_ok  <= 1'b1;
                end
                plct_pkg::UOP_DIV_INIT: r_dcnt <= plct_pkg::DIV_STEPS;
                plct_pkg::UOP_DIV_STEP: r_dcnt <= r_dcnt - plct_pkg::DCNT_W'(1);
                default: ;
            endcase
        end
    end

    // transaction payload and scan registers
    always_ff @(posedge i_clk) begin
        unique case (i_uop)
            plct_pkg::UOP_LATCH: begin
                r_cmd   <= plct_pkg::t_cmd'(i_cmd);
                r_q     <= ins_cmd ? plct_pkg::clamp_one(i_pos) : i_pos;
                r_v     <= ins_cmd ? plct_pkg::clamp_one(i_value) : i_value;
                r_idx   <= i_index;
                r_where <= '0;
                r_cv    <= '0;
                r_miss  <= 1'b0;
                r_full  <= 1'b0;
                r_hit   <= 1'b0;
                r_k     <= '0;
            end
            plct_pkg::UOP_SCAN_INIT: r_ptr <= '0;
            plct_pkg::UOP_EMPTY: begin
                r_k   <= '0;
                r_hit <= 1'b0;
            end
            plct_pkg::UOP_PREV: begin
                r_p0  <= r_rd_pos;
                r_v0  <= r_rd_val;
                r_ptr <= CW'(1);
            end
            plct_pkg::UOP_SCAN_NEXT: begin
                r_p0  <= r_rd_pos;
                r_v0  <= r_rd_val;
                r_ptr <= r_ptr + CW'(1);
            end
            plct_pkg::UOP_SCAN_HIT: begin
                r_k   <= r_ptr;
                r_p1  <= r_rd_pos;
                r_v1  <= r_rd_val;
                r_hit <= 1'b1;
            end
            plct_pkg::UOP_SCAN_END: begin
                r_k   <= r_count;
                r_hit <= 1'b0;
            end
            plct_pkg::UOP_EVAL_MISS: begin
                r_miss <= 1'b1;
                r_cv   <= '0;
                r_v    <= '0;
            end
            plct_pkg::UOP_EVAL_FLAT: begin
                r_cv <= flat_cv;
                r_v  <= flat_cv;
            end
            plct_pkg::UOP_DIV_INIT: begin
                r_num <= dv * dq;
                r_den <= dp;
                r_rem <= '0;
                r_neg <= dv_neg ^ dq_neg ^ dp_neg;
            end
            plct_pkg::UOP_DIV_STEP: begin
                r_rem <= qbit ? sub_res[VW-1:0] : trial[VW-1:0];
                r_num <= {r_num[PW-2:0], qbit};
            end
            plct_pkg::UOP_EVAL_FIN: begin
                r_cv <= fin_cv;
                r_v  <= fin_cv;
            end
            plct_pkg::UOP_INS_FOUND: r_where <= r_k[IW-1:0];
            plct_pkg::UOP_INS_FULL:  r_full  <= 1'b1;
            plct_pkg::UOP_SH_INIT:   r_ptr   <= r_count;
            plct_pkg::UOP_SH_PLACE:  r_where <= r_k[IW-1:0];
            plct_pkg::UOP_SH_DEC:    r_ptr   <= r_ptr - CW'(1);
            plct_pkg::UOP_DEL_INIT:  r_ptr   <= CW'(r_idx);
            plct_pkg::UOP_DEL_INC:   r_ptr   <= r_ptr + CW'(1);
            default: ;
        endcase
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_uop == plct_pkg::UOP_RESPOND) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_uop == plct_pkg::UOP_RESPOND) begin
            r_out_where   <= r_where;
            r_out_cv      <= r_cv;
            r_out_miss    <= r_miss;
            r_out_full    <= r_full;
            r_out_act_ok  <= r_act_ok;
            r_out_act_sel <= r_act_sel;
            r_out_count   <= r_count;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_result_index = r_out_where;
    assign o_curve_value  = r_out_cv;
    assign o_miss         = r_out_miss;
    assign o_full_res     = r_out_full;
    assign o_active_valid = r_out_act_ok;
    assign o_active_index = r_out_act_sel;
    assign o_point_count  = r_out_count;

`include "piecewise_linear_curve_table_unit_assert.svh"

    `PLCT_ASSERT_ALWAYS(a_count_range, i_clk, i_rst_n, r_count <= plct_pkg::MAX_CNT, "point count above table size")
    `PLCT_ASSERT_IMPLY(a_respond_free, i_clk, i_rst_n, i_uop == plct_pkg::UOP_RESPOND, !r_out_valid || i_ready, "result overwritten before taken")
    `PLCT_ASSERT_IMPLY(a_full_index, i_clk, i_rst_n, r_out_valid && r_out_full, r_out_where == '0 && r_out_cv <= plct_pkg::ONE_VAL, "refused insert reports bad result")
    `PLCT_ASSERT_NEXT(a_place_grows, i_clk, i_rst_n, i_uop == plct_pkg::UOP_SH_PLACE, r_count == $past(r_count) + CW'(1), "placed point did not grow table")

endmodule

// ----- hw/rtl/piecewise_linear_curve_table_unit.sv -----
// Curve table of up to 32 (position, value) points in 1.12 fixed point. One command is
// taken at a time: clear, overwrite, set active and the no-op go straight to the response;
// evaluate and inserts scan the table entry by entry after a short start, and evaluate and
// an interpolated insert then run a 26-step restoring divide when the segment has width;
// an insert that adds a point moves later entries up one by one, and delete moves
// entries down one by one. Scan and shift split the N entries between them.
// The finished result sits in an output register, so a new command may be taken while
// it waits. merge_distance is an APB register at byte address 0.
// ----------------------------------------------------------------------------
// piecewise_linear_curve_table_unit
// Top level: APB register, sequencer and curve table datapath.
// ----------------------------------------------------------------------------
module piecewise_linear_curve_table_unit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic [2:0]                          i_cmd,
    input  logic [plct_pkg::VAL_W-1:0]          i_pos,
    input  logic [plct_pkg::VAL_W-1:0]          i_value,
    input  logic [plct_pkg::IDX_W-1:0]          i_index,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic [plct_pkg::IDX_W-1:0]          o_result_index,
    output logic [plct_pkg::VAL_W-1:0]          o_curve_value,
    output logic                                o_miss,
    output logic                                o_full_res,
    output logic                                o_active_valid,
    output logic [plct_pkg::IDX_W-1:0]          o_active_index,
    output logic [plct_pkg::CNT_W-1:0]          o_point_count,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [plct_pkg::CFG_ADDR_W-1:0]     paddr,
    input  logic [31:0]                         pwdata,
    output logic [31:0]                         prdata,
    output logic                                pready
);

    logic [plct_pkg::VAL_W-1:0] r_merge;
    plct_pkg::t_dp_stat         stat;
    plct_pkg::t_uop             uop;

    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_merge <= plct_pkg::MERGE_DIST_RST;
        end else if (psel && penable && pwrite && (paddr[2] == plct_pkg::REG_MERGE_DIST)) begin
            r_merge <= pwdata[plct_pkg::VAL_W-1:0];
        end
    end

    assign prdata = (paddr[2] == plct_pkg::REG_MERGE_DIST) ? 32'(r_merge) : '0;

    plct_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_stat  (stat),
        .o_ready (o_ready),
        .o_uop   (uop)
    );

    plct_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_uop          (uop),
        .i_merge        (r_merge),
        .i_cmd          (i_cmd),
        .i_pos          (i_pos),
        .i_value        (i_value),
        .i_index        (i_index),
        .i_ready        (i_ready),
        .o_stat         (stat),
        .o_valid        (o_valid),
        .o_result_index (o_result_index),
        .o_curve_value  (o_curve_value),
        .o_miss         (o_miss),
        .o_full_res     (o_full_res),
        .o_active_valid (o_active_valid),
        .o_active_index (o_active_index),
        .o_point_count  (o_point_count)
    );

endmodule
